/* design/point_add_range_sum_tree_top_assert.svh */
// Assertion macros for the point-add range-sum tree.
`ifndef POINT_ADD_RANGE_SUM_TREE_TOP_ASSERT_SVH
`define POINT_ADD_RANGE_SUM_TREE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define PASRT_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PASRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PASRT_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define PASRT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* design/pasrt_pkg.sv */
// Shared constants and types for the point-add range-sum tree.
`timescale 1ns / 1ps

package pasrt_pkg;

  localparam int unsigned TREE_SIZE_DEF = 1024;
  localparam int unsigned SUM_W         = 64;
  localparam int unsigned POS_W         = 10;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_LEAF,
    ST_UPD_NODE,
    ST_QRY_LEFT,
    ST_QRY_RIGHT,
    ST_QRY_OUT
  } state_e;

endpackage

/* design/pasrt_node_ram.sv */
// Node-sum memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module pasrt_node_ram #(
  parameter int unsigned DEPTH = 2 * pasrt_pkg::TREE_SIZE_DEF,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AddrW-1:0]              waddr_i,
  input  logic [pasrt_pkg::SUM_W-1:0]   wdata_i,
  input  logic [AddrW-1:0]              raddr_i,
  output logic [pasrt_pkg::SUM_W-1:0]   rdata_o
);

  logic [pasrt_pkg::SUM_W-1:0] mem_q [DEPTH];
  logic [pasrt_pkg::SUM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/point_add_range_sum_tree_top.sv */
// Top level of the point-add range-sum tree: command FSM around the node memory.
`timescale 1ns / 1ps
`include "point_add_range_sum_tree_top_assert.svh"

// Segment tree of wrapping 64-bit partial sums over TREE_SIZE positions.
// Command channel: an item transfers on a rising edge with start_i high and
// busy_o low. mode_i = 0 adds delta_i at position_i (positions at or beyond
// TREE_SIZE are dropped) and gives no result. mode_i = 1 sums the inclusive
// range range_low_i..range_high_i (high end clamped to TREE_SIZE-1; an empty
// range gives zero) and gives one result.
// Result channel: range_sum_o is valid for exactly one cycle while
// range_sum_valid_o is high; the receiver cannot stall it. busy_o falls in
// the cycle after the strobe.
// Sequencing: an add keeps busy_o high while it writes the leaf, then does one
// read-modify-write per ancestor level through the single read port; no new
// item transfers until it is done. A query walks the nodes in steps, each a
// left-bound state then a right-bound state, up to log2(TREE_SIZE) + 1 steps,
// then a left-bound state that sees the walk end (at once for an empty range)
// and a strobe state; the next item can transfer once busy_o falls.
// Reset: after rst_ni rises, a clearing pass writes zero to all 2*TREE_SIZE
// nodes, one per cycle; busy_o stays high until it ends.
module point_add_range_sum_tree_top #(
  parameter int unsigned TREE_SIZE = pasrt_pkg::TREE_SIZE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                mode_i,
  input  logic        [pasrt_pkg::POS_W-1:0]  position_i,
  input  logic signed [pasrt_pkg::SUM_W-1:0]  delta_i,
  input  logic        [pasrt_pkg::POS_W-1:0]  range_low_i,
  input  logic        [pasrt_pkg::POS_W-1:0]  range_high_i,
  output logic                                range_sum_valid_o,
  output logic signed [pasrt_pkg::SUM_W-1:0]  range_sum_o
);

  localparam int unsigned Depth = 2 * TREE_SIZE;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = AddrW + 1;
  localparam logic [31:0] N32   = 32'(TREE_SIZE);

  pasrt_pkg::state_e state_q, state_d;

  logic [AddrW-1:0]            clr_q, clr_d;
  logic [AddrW-1:0]            k_q, k_d;
  logic [CntW-1:0]             l_q, l_d, r_q, r_d;
  logic [pasrt_pkg::SUM_W-1:0] delta_q, delta_d;
  logic [pasrt_pkg::SUM_W-1:0] val_q, val_d;
  logic [pasrt_pkg::SUM_W-1:0] acc_q, acc_d;
  logic                        pend_q, pend_d;

  logic                        ram_we;
  logic [AddrW-1:0]            ram_waddr, ram_raddr;
  logic [pasrt_pkg::SUM_W-1:0] ram_wdata, ram_rdata;

  logic                        accept;
  logic [31:0]                 pos32, lo32, hi32, hi_sat32;
  logic                        empty;
  logic [CntW-1:0]             r_start;
  logic [pasrt_pkg::SUM_W-1:0] upd_sum;
  logic [AddrW-1:0]            parent;
  logic [CntW-1:0]             r_dec;

  pasrt_node_ram #(
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign accept   = start_i && (state_q == pasrt_pkg::ST_IDLE);
  assign pos32    = 32'(position_i);
  assign lo32     = 32'(range_low_i);
  assign hi32     = 32'(range_high_i);
  assign hi_sat32 = (hi32 >= N32) ? (N32 - 32'd1) : hi32;
  assign empty    = lo32 > hi_sat32;
  assign r_start  = CntW'(hi_sat32 + N32 + 32'd1);
  assign upd_sum  = ((state_q == pasrt_pkg::ST_UPD_LEAF) ? delta_q : val_q) + ram_rdata;
  assign parent   = k_q >> 1;
  assign r_dec    = r_q - CntW'(1);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    k_d       = k_q;
    l_d       = l_q;
    r_d       = r_q;
    delta_d   = delta_q;
    val_d     = val_q;
    acc_d     = pend_q ? (acc_q + ram_rdata) : acc_q;
    pend_d    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = k_q;
    ram_wdata = upd_sum;
    ram_raddr = '0;
    unique case (state_q)
      pasrt_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = pasrt_pkg::ST_IDLE;
        end
      end
      pasrt_pkg::ST_IDLE: begin
        if (accept) begin
          if (mode_i == pasrt_pkg::MODE_ADD) begin
            // drop adds beyond the tree
            if (pos32 < N32) begin
              k_d       = AddrW'(pos32 + N32);
              ram_raddr = AddrW'(pos32 + N32);
              delta_d   = delta_i;
              state_d   = pasrt_pkg::ST_UPD_LEAF;
            end
          end else begin
            r_d     = r_start;
            l_d     = empty ? r_start : CntW'(lo32 + N32);
            acc_d   = '0;
            state_d = pasrt_pkg::ST_QRY_LEFT;
          end
        end
      end
      pasrt_pkg::ST_UPD_LEAF: begin
        // write the leaf and fetch its sibling for the parent sum
        ram_we    = 1'b1;
        ram_waddr = k_q;
        val_d     = upd_sum;
        ram_raddr = k_q ^ AddrW'(1);
        state_d   = pasrt_pkg::ST_UPD_NODE;
      end
      pasrt_pkg::ST_UPD_NODE: begin
        ram_we    = 1'b1;
        ram_waddr = parent;
        val_d     = upd_sum;
        k_d       = parent;
        if (parent == AddrW'(1)) begin
          state_d = pasrt_pkg::ST_IDLE;
        end else begin
          ram_raddr = parent ^ AddrW'(1);
        end
      end
      pasrt_pkg::ST_QRY_LEFT: begin
        if (l_q >= r_q) begin
          state_d = pasrt_pkg::ST_QRY_OUT;
        end else begin
          if (l_q[0]) begin
            ram_raddr = l_q[AddrW-1:0];
            pend_d    = 1'b1;
            l_d       = l_q + CntW'(1);
          end
          state_d = pasrt_pkg::ST_QRY_RIGHT;
        end
      end
      pasrt_pkg::ST_QRY_RIGHT: begin
        l_d = l_q >> 1;
        if (r_q[0]) begin
          ram_raddr = r_dec[AddrW-1:0];
          pend_d    = 1'b1;
          r_d       = r_dec >> 1;
        end else begin
          r_d = r_q >> 1;
        end
        state_d = pasrt_pkg::ST_QRY_LEFT;
      end
      pasrt_pkg::ST_QRY_OUT: begin
        state_d = pasrt_pkg::ST_IDLE;
      end
      default: begin
        state_d = pasrt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pasrt_pkg::ST_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    l_q     <= l_d;
    r_q     <= r_d;
    delta_q <= delta_d;
    val_q   <= val_d;
    acc_q   <= acc_d;
  end

  assign busy_o            = state_q != pasrt_pkg::ST_IDLE;
  assign range_sum_valid_o = state_q == pasrt_pkg::ST_QRY_OUT;
  assign range_sum_o       = acc_q;

  `PASRT_ASSERT_ALWAYS(a_strobe_while_busy, clk_i, range_sum_valid_o |-> busy_o, "result strobe while idle")
  `PASRT_ASSERT_RST(a_strobe_one_cycle, clk_i, rst_ni, range_sum_valid_o |=> !range_sum_valid_o && !busy_o, "result strobe not followed by idle")
  `PASRT_ASSERT_RST(a_upd_below_root, clk_i, rst_ni, (state_q == pasrt_pkg::ST_UPD_NODE) |-> (k_q > AddrW'(1)), "update walked past the root")
  `PASRT_ASSERT_RST(a_no_rw_collide, clk_i, rst_ni, (ram_we && (state_q != pasrt_pkg::ST_CLEAR)) |-> (ram_waddr != ram_raddr), "read and write hit the same node")
  `PASRT_ASSERT_RST(a_query_no_write, clk_i, rst_ni, ((state_q == pasrt_pkg::ST_QRY_LEFT) || (state_q == pasrt_pkg::ST_QRY_RIGHT)) |-> !ram_we, "memory written during a query")

endmodule
